>>> sv/spq_pkg.sv
package spq_pkg;

  // Default sizing
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TagBitsDef    = 16;

  // Fixed field widths
  localparam int unsigned TagFieldW  = 16;
  localparam int unsigned PrioW      = 3;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned NumLevels  = 3;

  // Request kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] ST_QUEUED   = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_PRIO = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
  localparam logic [StatusW-1:0] ST_DEQUEUED = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_LEVEL_ONE   = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_LEVEL_TWO   = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_LEVEL_THREE = 2'd2;

  // Reset codes
  localparam logic [PrioW-1:0] LEVEL_ONE_RST   = 3'd1;
  localparam logic [PrioW-1:0] LEVEL_TWO_RST   = 3'd2;
  localparam logic [PrioW-1:0] LEVEL_THREE_RST = 3'd3;

  typedef struct packed {
    logic                 kind;
    logic [TagFieldW-1:0] job_tag;
    logic [PrioW-1:0]     priority_req;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [TagFieldW-1:0] out_tag;
    logic [PrioW-1:0]     out_priority;
  } rsp_t;

  // Per-queue control into the cell chain
  typedef struct packed {
    logic shift;  // pop head, everything moves one cell toward the head
    logic load;   // push at the first empty cell
  } cell_ctrl_t;

endpackage

>>> sv/spq_cell.sv
module spq_cell import spq_pkg::*; #(
  parameter int unsigned TAG_BITS = TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [TAG_BITS-1:0] push_tag_i,
  input  logic                prev_valid_i,  // neighbor toward the head
  input  logic                next_valid_i,  // neighbor toward the tail
  input  logic [TAG_BITS-1:0] next_tag_i,
  output logic                valid_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic                valid_d, valid_q;
  logic [TAG_BITS-1:0] tag_d, tag_q;

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      tag_d   = next_tag_i;
    end else if (ctrl_i.load && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      tag_d   = push_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;

endmodule

>>> sv/spq_chain.sv
module spq_chain import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [TAG_BITS-1:0] push_tag_i,
  output logic                nonempty_o,
  output logic                full_o,
  output logic [TAG_BITS-1:0] head_tag_o
);

  logic                valid [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag   [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                prev_valid;
    logic                next_valid;
    logic [TAG_BITS-1:0] next_tag;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_tag   = '0;
    end else begin : g_inner
      assign next_valid = valid[i+1];
      assign next_tag   = tag[i+1];
    end

    spq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .push_tag_i  (push_tag_i),
      .prev_valid_i(prev_valid),
      .next_valid_i(next_valid),
      .next_tag_i  (next_tag),
      .valid_o     (valid[i]),
      .tag_o       (tag[i])
    );
  end

  assign nonempty_o = valid[0];
  assign full_o     = valid[QUEUE_DEPTH-1];
  assign head_tag_o = tag[0];

endmodule

>>> sv/strict_priority_three_level_queue.sv
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_ready_o    in_data_i  (req_t: kind, job_tag, priority_req)
// out      out  out_valid_o / out_ready_i  out_data_o (rsp_t: status, out_tag, out_priority)
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i (level codes)
//
// One transfer per cycle while out_ready_i is high; each request yields one result
// in the next cycle. An enqueue fills a queue's first empty cell; a dequeue shifts
// that chain one cell toward the head.
// Reset empties all queues (cell valid bits) and restores codes 1, 2, 3.
// in_ready_o drops only while a result is held and out_ready_i is low.
// cfg_ready_o is always high; codes take effect on the next request.
module strict_priority_three_level_queue import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [PrioW-1:0]     cfg_data_i
);

  // Level codes, one per queue; queue 0 is served first.
  logic [PrioW-1:0] code_q [NumLevels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q[0] <= LEVEL_ONE_RST;
      code_q[1] <= LEVEL_TWO_RST;
      code_q[2] <= LEVEL_THREE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LEVEL_ONE:   code_q[0] <= cfg_data_i;
        CFG_LEVEL_TWO:   code_q[1] <= cfg_data_i;
        CFG_LEVEL_THREE: code_q[2] <= cfg_data_i;
        default: ;  // index outside the register list: dropped
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Tag width adaption between the 16-bit field and the stored width.
  logic [TAG_BITS-1:0]  push_tag;
  logic [TAG_BITS-1:0]  pop_tag;
  logic [TagFieldW-1:0] pop_tag_field;

  if (TAG_BITS >= TagFieldW) begin : g_wide_tag
    assign push_tag      = TAG_BITS'(in_data_i.job_tag);
    assign pop_tag_field = pop_tag[TagFieldW-1:0];
  end else begin : g_narrow_tag
    assign push_tag      = in_data_i.job_tag[TAG_BITS-1:0];
    assign pop_tag_field = TagFieldW'(pop_tag);
  end

  // Queue chains
  cell_ctrl_t          ctrl     [NumLevels];
  logic                nonempty [NumLevels];
  logic                full     [NumLevels];
  logic [TAG_BITS-1:0] head_tag [NumLevels];

  for (genvar q = 0; q < NumLevels; q++) begin : g_queue
    spq_chain #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TAG_BITS   (TAG_BITS)
    ) u_chain (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[q]),
      .push_tag_i(push_tag),
      .nonempty_o(nonempty[q]),
      .full_o    (full[q]),
      .head_tag_o(head_tag[q])
    );
  end

  // Request decode
  logic in_fire;
  logic out_valid_q;
  rsp_t out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic hit;
    hit     = 1'b0;
    pop_tag = '0;
    out_d   = '0;
    for (int q = 0; q < NumLevels; q++) begin
      ctrl[q] = '0;
    end

    if (in_data_i.kind == KIND_ENQ) begin
      // Lowest numbered queue with a matching code takes the job.
      out_d.status = ST_BAD_PRIO;
      for (int q = 0; q < NumLevels; q++) begin
        if (!hit && code_q[q] == in_data_i.priority_req) begin
          hit = 1'b1;
          if (full[q]) begin
            out_d.status = ST_FULL;
          end else begin
            out_d.status = ST_QUEUED;
            ctrl[q].load = in_fire;
          end
        end
      end
    end else begin
      // Strict priority: first non-empty queue gives up its head.
      out_d.status = ST_EMPTY;
      for (int q = 0; q < NumLevels; q++) begin
        if (!hit && nonempty[q]) begin
          hit                = 1'b1;
          pop_tag            = head_tag[q];
          out_d.out_priority = code_q[q];
          out_d.status       = ST_DEQUEUED;
          ctrl[q].shift      = in_fire;
        end
      end
      out_d.out_tag = pop_tag_field;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/spq_checker.sv
module spq_checker import spq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // A held result stays until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every accepted request shows a result on the next cycle.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("no result after request transfer");

  // Dequeue requests answer only with dequeued or empty.
  a_deq_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.kind == KIND_DEQ |=>
      (out_data_o.status == ST_DEQUEUED || out_data_o.status == ST_EMPTY))
    else $error("bad status for dequeue");

  // Enqueue requests answer only with queued, bad priority or full.
  a_enq_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.kind == KIND_ENQ |=>
      (out_data_o.status == ST_QUEUED || out_data_o.status == ST_BAD_PRIO ||
       out_data_o.status == ST_FULL))
    else $error("bad status for enqueue");

  // Tag and priority are zero unless a job left a queue.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_DEQUEUED |->
      out_data_o.out_tag == '0 && out_data_o.out_priority == '0)
    else $error("nonzero payload on non-dequeue result");

endmodule

bind strict_priority_three_level_queue spq_checker u_spq_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  typedef logic [PrioW-1:0] code_t;

  // The index just past the three level registers. A write to it must change nothing.
  localparam logic [CfgIndexW-1:0] CFG_UNMAPPED = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // DUT-facing signals. Every input is known from time zero.
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  code_t cfg_data = '0;

  // Shadow of the queue contents and the level codes.
  logic [TagFieldW-1:0] tag_store [NumLevels][QueueDepthDef];
  int unsigned head_slot [NumLevels];
  int unsigned fill_cnt [NumLevels];
  code_t lvl_code [NumLevels];

  req_t pend_q [$];   // requests that are not yet transferred
  rsp_t exp_q [$];    // predicted results, oldest first

  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;    // set for the final stretch: no gaps, no stalls

  // State of the random gaps on each side.
  int send_gap = 0, send_stretch = 0, send_g;
  bit send_choppy;
  int stall_left = 0, rcv_stretch = 0, rcv_g;
  bit rcv_choppy;

  strict_priority_three_level_queue DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length of a gap to insert now, or zero. Traffic alternates between stretches
  // that have gaps and stretches that run clean.
  function automatic int gap_len(inout int stretch, inout bit choppy);
    if (calm) return 0;
    if (stretch == 0) begin
      stretch = $urandom_range(10, 60);
      choppy  = 1'($urandom_range(0, 1));
    end
    stretch--;
    if (choppy && $urandom_range(0, 3) == 0) return $urandom_range(1, 7);
    return 0;
  endfunction

  // Three FIFOs. Enqueue goes to the lowest level whose code matches. Dequeue
  // takes the head of the first level that is not empty.
  function automatic rsp_t predict_rsp(req_t r);
    rsp_t res;
    bit hit;
    int unsigned slot;
    res = '0;
    hit = 1'b0;
    if (r.kind == KIND_ENQ) begin
      res.status = ST_BAD_PRIO;
      for (int q = 0; q < NumLevels; q++) begin
        if (!hit && lvl_code[q] == r.priority_req) begin
          hit = 1'b1;
          if (fill_cnt[q] >= QueueDepthDef) begin
            res.status = ST_FULL;           // dropped, nothing moves
          end else begin
            slot = (head_slot[q] + fill_cnt[q]) % QueueDepthDef;
            tag_store[q][slot] = r.job_tag;
            fill_cnt[q]++;
            res.status = ST_QUEUED;
          end
        end
      end
    end else begin
      res.status = ST_EMPTY;
      for (int q = 0; q < NumLevels; q++) begin
        if (!hit && fill_cnt[q] != 0) begin
          hit = 1'b1;
          res.status       = ST_DEQUEUED;
          res.out_tag      = tag_store[q][head_slot[q]];
          res.out_priority = lvl_code[q];  // the code in force now, not at enqueue
          head_slot[q]     = (head_slot[q] + 1) % QueueDepthDef;
          fill_cnt[q]--;
        end
      end
    end
    return res;
  endfunction

  function automatic req_t enq_item(logic [TagFieldW-1:0] tag, code_t prio);
    req_t r;
    r.kind         = KIND_ENQ;
    r.job_tag      = tag;
    r.priority_req = prio;
    return r;
  endfunction

  // The tag and priority fields of a dequeue carry noise. The DUT must ignore them.
  function automatic req_t deq_item();
    req_t r;
    r.kind         = KIND_DEQ;
    r.job_tag      = TagFieldW'($urandom);
    r.priority_req = PrioW'($urandom_range(0, 7));
    return r;
  endfunction

  // Most enqueues use a code that is in force. About one in six uses any code.
  function automatic req_t rand_item(int enq_pct);
    code_t prio;
    if ($urandom_range(0, 99) >= enq_pct) return deq_item();
    if ($urandom_range(0, 5) == 0) prio = PrioW'($urandom_range(0, 7));
    else prio = lvl_code[$urandom_range(0, NumLevels - 1)];
    return enq_item(TagFieldW'($urandom), prio);
  endfunction

  task automatic queue_random(int count, int enq_pct);
    repeat (count) pend_q.push_back(rand_item(enq_pct));
  endtask

  // Queues are checked on the falling edge, so no clocked block is updating them.
  task automatic wait_idle();
    do @(negedge clk); while (pend_q.size() != 0 || exp_q.size() != 0);
  endtask

  // Each write starts on a fresh edge, so cfg_valid never gets two updates in one step.
  task automatic write_code(logic [CfgIndexW-1:0] idx, code_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NumLevels) lvl_code[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  // Request driver: holds valid and data until the transfer happens, then moves on.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) pend_q.delete(0);
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        send_g = gap_len(send_stretch, send_choppy);
        if (send_g != 0) begin
          send_gap = send_g - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pend_q[0];
        end
      end
    end
  end

  // Result-side backpressure. The stalls do not depend on out_valid.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      rcv_g = gap_len(rcv_stretch, rcv_choppy);
      if (rcv_g != 0) begin
        stall_left = rcv_g - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor. Predict first, then check. The order is still right if a result
  // comes out in the same cycle as its request.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (in_valid && in_ready) exp_q.push_back(predict_rsp(in_data));
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          $display("%0t: result with none expected: actual %h", $time, out_data);
          errors++;
        end else begin
          want = exp_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_data.status);
            errors++;
          end
          if (out_data.out_tag !== want.out_tag) begin
            $display("%0t: out_tag mismatch: expected %h, actual %h",
                     $time, want.out_tag, out_data.out_tag);
            errors++;
          end
          if (out_data.out_priority !== want.out_priority) begin
            $display("%0t: out_priority mismatch: expected %0d, actual %0d",
                     $time, want.out_priority, out_data.out_priority);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: any transfer on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    code_t codes [NumLevels];
    int enq_pct;
    head_slot = '{default: 0};
    fill_cnt  = '{default: 0};
    lvl_code  = '{LEVEL_ONE_RST, LEVEL_TWO_RST, LEVEL_THREE_RST};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset codes. Dequeue while empty. Tag extremes. Codes that no
    // level holds, including 0 and 7. Service order across the levels.
    pend_q.push_back(deq_item());
    pend_q.push_back(enq_item(16'hFFFF, LEVEL_THREE_RST));
    pend_q.push_back(enq_item(16'h0000, LEVEL_ONE_RST));
    pend_q.push_back(enq_item(16'h1234, LEVEL_TWO_RST));
    pend_q.push_back(enq_item(16'h5A5A, 3'd0));
    pend_q.push_back(enq_item(16'hA5A5, 3'd7));
    repeat (4) pend_q.push_back(deq_item());
    pend_q.push_back(enq_item(16'h0A0A, LEVEL_ONE_RST));
    pend_q.push_back(enq_item(16'h0B0B, LEVEL_TWO_RST));
    pend_q.push_back(enq_item(16'h0C0C, LEVEL_THREE_RST));
    wait_idle();

    // Change the codes while jobs still wait. Levels one and two share a code,
    // so level one takes the enqueue. The write to the unmapped index is dropped.
    write_code(CFG_LEVEL_ONE, 3'd7);
    write_code(CFG_LEVEL_TWO, 3'd7);
    write_code(CFG_LEVEL_THREE, 3'd0);
    write_code(CFG_UNMAPPED, 3'd5);
    pend_q.push_back(enq_item(16'h0D0D, 3'd7));
    pend_q.push_back(enq_item(16'h0E0E, 3'd0));
    pend_q.push_back(enq_item(16'h0F0F, LEVEL_ONE_RST));
    pend_q.push_back(enq_item(16'h1010, LEVEL_THREE_RST));
    repeat (6) pend_q.push_back(deq_item());
    wait_idle();

    // Random phases. Each phase has one set of codes. Enqueue-heavy chunks fill
    // the queues until they reject. The last chunk drains toward empty.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: codes = '{LEVEL_ONE_RST, LEVEL_TWO_RST, LEVEL_THREE_RST};
        1: codes = '{3'd7, 3'd0, 3'd5};
        2: codes = '{3'd0, 3'd0, 3'd0};
        3: codes = '{3'd7, 3'd7, 3'd7};
        4: codes = '{3'd6, 3'd4, 3'd6};
        default: begin
          foreach (codes[i]) codes[i] = PrioW'($urandom_range(0, 7));
        end
      endcase
      write_code(CFG_LEVEL_ONE, codes[0]);
      write_code(CFG_LEVEL_TWO, codes[1]);
      write_code(CFG_LEVEL_THREE, codes[2]);
      for (int ch = 0; ch < 4; ch++) begin
        case (ch)
          0, 1: enq_pct = 80;
          2: enq_pct = $urandom_range(30, 70);
          default: enq_pct = 20;
        endcase
        // Once per phase the sender waits until every result is back.
        if (ch == 2) wait_idle();
        queue_random(55, enq_pct);
        do @(negedge clk); while (pend_q.size() > 10);
      end
      wait_idle();
    end

    // Closing stretch at full rate: no gaps, no stalls.
    calm = 1'b1;
    queue_random(120, 60);
    wait_idle();
    repeat (10) @(posedge clk);

    if (errors == 0 && exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/spq_chain.sv
sv/strict_priority_three_level_queue.sv
sv/spq_checker.sv
tb/tb.sv
